@@ rtl/single_source_shortest_distance_top_assert.svh @@
// Assertion macros for the shortest distance block.
`ifndef SINGLE_SOURCE_SHORTEST_DISTANCE_TOP_ASSERT_SVH
`define SINGLE_SOURCE_SHORTEST_DISTANCE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SSD_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSD_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ssd_pkg.sv @@
// Shared types and constants of the shortest distance block.
package ssd_pkg;

  localparam int MAX_VERTS_DEF = 32;
  localparam int COST_BITS_DEF = 16;

  localparam int REG_W       = 6;
  localparam int EDGE_COST_W = 16;
  localparam int DIST_W      = 21;
  localparam int CFG_IDX_W   = 2;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET       = 2'd2;

  localparam logic [REG_W-1:0] VERTEX_COUNT_RST = 6'd1;
  localparam logic [REG_W-1:0] SOURCE_RST       = 6'd1;
  localparam logic [REG_W-1:0] TARGET_RST       = 6'd6;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ECMP,
    S_EWB,
    S_INIT,
    S_RELAX,
    S_PICK,
    S_TREAD,
    S_RESULT
  } state_t;

endpackage

@@ rtl/ssd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ssd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/single_source_shortest_distance_top.sv @@
// Top level of the shortest distance block: edge store, distance memory, sequencer.
// An edge item goes through a compare state, plus a write-back state if its weight changes.
// A final edge adds setup, a relaxation round per reached vertex, a target read, the result
// and a MAX_VERTS*MAX_VERTS word clear; an invalid source or target goes to the result.
// The result state holds while an earlier result is still stalled.
// Reset sets the registers to 1, 1, 6 and runs the same clearing pass before the first item.
`include "single_source_shortest_distance_top_assert.svh"

module single_source_shortest_distance_top
  import ssd_pkg::*;
#(
  parameter int MAX_VERTS = MAX_VERTS_DEF,
  parameter int COST_BITS = COST_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [REG_W-1:0]       edge_from,
  input  logic [REG_W-1:0]       edge_to,
  input  logic [EDGE_COST_W-1:0] edge_cost,
  input  logic                   final_edge,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DIST_W-1:0]      distance,
  output logic                   reachable,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [REG_W-1:0]       cfg_data
);

  localparam int IW    = $clog2(MAX_VERTS);
  localparam int VW    = $clog2(MAX_VERTS + 1);
  localparam int DEPTH = MAX_VERTS * MAX_VERTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = COST_BITS + 1;
  localparam int SW    = ((COST_BITS > DIST_W) ? COST_BITS : DIST_W) + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  state_t state, state_next;

  logic [REG_W-1:0] vertex_count, source_vertex, target_vertex;
  logic [VW-1:0]    n_act;

  logic           e_we;
  logic [AW-1:0]  e_waddr, e_raddr;
  logic [EW-1:0]  e_wdata, e_rdata;
  logic           b_we;
  logic [IW-1:0]  b_waddr, b_raddr;
  logic [DIST_W-1:0] b_wdata, b_rdata;

  logic [AW-1:0]  clr_addr;

  logic [IW-1:0]        e_a, e_b;
  logic [COST_BITS-1:0] e_cost_r;
  logic                 e_ok, e_final;

  logic                 in_ok;
  logic [IW-1:0]        in_a, in_b;
  logic [AW-1:0]        in_addr, e_addr_ab, e_addr_ba;
  logic                 e_upd;

  logic                 s_ok;
  logic [IW-1:0]        s_idx, t_idx;

  logic [MAX_VERTS-1:0] settled, reach;
  logic [IW-1:0]        u;
  logic [DIST_W-1:0]    du;
  logic [AW-1:0]        ubase;
  logic [VW-1:0]        ri;
  logic                 issue;

  logic                 p_v;
  logic [IW-1:0]        p_i;
  logic [SW-1:0]        sum;
  logic [DIST_W-1:0]    cand, p_val;
  logic                 p_live, r_upd, p_keep;

  logic                 q_v;
  logic [IW-1:0]        q_i;
  logic [DIST_W-1:0]    q_val;

  logic                 m_found;
  logic [IW-1:0]        m_idx;
  logic [DIST_W-1:0]    m_val;

  logic [DIST_W-1:0]    res_dist;
  logic                 res_reach;
  logic                 out_free;

  function automatic logic vin(input logic [REG_W-1:0] v, input logic [VW-1:0] cnt);
    vin = (v != '0) && (32'(v) <= 32'(cnt));
  endfunction

  assign cfg_ready = 1'b1;

  assign n_act = (32'(vertex_count) > MAX_VERTS) ? VW'(MAX_VERTS) : VW'(vertex_count);

  assign in_ok   = vin(edge_from, n_act) && vin(edge_to, n_act);
  assign in_a    = IW'(edge_from - 1'b1);
  assign in_b    = IW'(edge_to - 1'b1);
  assign in_addr = AW'(AW'(in_a) * AW'(MAX_VERTS) + AW'(in_b));

  assign e_addr_ab = AW'(AW'(e_a) * AW'(MAX_VERTS) + AW'(e_b));
  assign e_addr_ba = AW'(AW'(e_b) * AW'(MAX_VERTS) + AW'(e_a));
  assign e_upd     = e_ok && (!e_rdata[COST_BITS] || (e_cost_r < e_rdata[COST_BITS-1:0]));

  assign s_ok  = vin(source_vertex, n_act) && vin(target_vertex, n_act);
  assign s_idx = IW'(source_vertex - 1'b1);
  assign t_idx = IW'(target_vertex - 1'b1);

  assign issue = (state == S_RELAX) && (ri != n_act);

  assign sum    = SW'(du) + SW'(e_rdata[COST_BITS-1:0]);
  assign cand   = (sum > SW'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
  assign p_live = p_v && !settled[p_i];
  assign r_upd  = p_live && e_rdata[COST_BITS] && (!reach[p_i] || (cand < b_rdata));
  assign p_val  = r_upd ? cand : b_rdata;
  assign p_keep = p_live && (reach[p_i] || r_upd);

  assign out_free = !out_valid || !out_stall;

  ssd_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_edge_ram (
    .clk  (clk),
    .we   (e_we),
    .waddr(e_waddr),
    .wdata(e_wdata),
    .raddr(e_raddr),
    .rdata(e_rdata)
  );

  ssd_ram #(
    .WIDTH(DIST_W),
    .DEPTH(MAX_VERTS)
  ) u_dist_ram (
    .clk  (clk),
    .we   (b_we),
    .waddr(b_waddr),
    .wdata(b_wdata),
    .raddr(b_raddr),
    .rdata(b_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == LAST_ADDR) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_ECMP;
      end
      S_ECMP: begin
        if (e_upd) state_next = S_EWB;
        else if (e_final) state_next = S_INIT;
        else state_next = S_IDLE;
      end
      S_EWB: begin
        state_next = e_final ? S_INIT : S_IDLE;
      end
      S_INIT: begin
        state_next = s_ok ? S_RELAX : S_RESULT;
      end
      S_RELAX: begin
        if ((ri == n_act) && !p_v && !q_v) state_next = S_PICK;
      end
      S_PICK: begin
        state_next = m_found ? S_RELAX : S_TREAD;
      end
      S_TREAD: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) state_next = S_CLEAR;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    e_we     = 1'b0;
    e_waddr  = clr_addr;
    e_wdata  = '0;
    e_raddr  = in_addr;
    b_we     = 1'b0;
    b_waddr  = p_i;
    b_wdata  = cand;
    b_raddr  = ri[IW-1:0];
    unique case (state)
      S_CLEAR: begin
        e_we = 1'b1;
      end
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_ECMP: begin
        e_we    = e_upd;
        e_waddr = e_addr_ab;
        e_wdata = {1'b1, e_cost_r};
      end
      S_EWB: begin
        e_we    = 1'b1;
        e_waddr = e_addr_ba;
        e_wdata = {1'b1, e_cost_r};
      end
      S_INIT: begin
        b_we    = s_ok;
        b_waddr = s_idx;
        b_wdata = '0;
      end
      S_RELAX: begin
        e_raddr = AW'(ubase + AW'(ri[IW-1:0]));
        b_we    = r_upd;
      end
      S_PICK: begin
        b_raddr = t_idx;
      end
      S_TREAD, S_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      vertex_count  <= VERTEX_COUNT_RST;
      source_vertex <= SOURCE_RST;
      target_vertex <= TARGET_RST;
      settled       <= '0;
      reach         <= '0;
      ri            <= '0;
      p_v           <= 1'b0;
      q_v           <= 1'b0;
      m_found       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_VERTEX_COUNT: vertex_count  <= cfg_data;
          CFG_SOURCE:       source_vertex <= cfg_data;
          CFG_TARGET:       target_vertex <= cfg_data;
          default: begin
          end
        endcase
      end

      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == S_RESULT) clr_addr <= '0;

      p_v <= issue;
      q_v <= p_keep;
      if (issue) ri <= ri + 1'b1;
      if (r_upd) reach[p_i] <= 1'b1;
      if (q_v && (!m_found || (q_val < m_val))) m_found <= 1'b1;

      if (state == S_INIT) begin
        settled <= MAX_VERTS'(1) << s_idx;
        reach   <= MAX_VERTS'(1) << s_idx;
        ri      <= '0;
        m_found <= 1'b0;
      end

      if ((state == S_PICK) && m_found) begin
        settled[m_idx] <= 1'b1;
        ri             <= '0;
        m_found        <= 1'b0;
      end

      if ((state == S_RESULT) && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      e_a      <= in_a;
      e_b      <= in_b;
      e_cost_r <= COST_BITS'(edge_cost);
      e_ok     <= in_ok;
      e_final  <= final_edge;
    end

    p_i   <= ri[IW-1:0];
    q_i   <= p_i;
    q_val <= p_val;

    if (q_v && (!m_found || (q_val < m_val))) begin
      m_idx <= q_i;
      m_val <= q_val;
    end

    if (state == S_INIT) begin
      u         <= s_idx;
      du        <= '0;
      ubase     <= AW'(AW'(s_idx) * AW'(MAX_VERTS));
      res_dist  <= '0;
      res_reach <= 1'b0;
    end

    if ((state == S_PICK) && m_found) begin
      u     <= m_idx;
      du    <= m_val;
      ubase <= AW'(AW'(m_idx) * AW'(MAX_VERTS));
    end

    if (state == S_TREAD) begin
      res_reach <= reach[t_idx];
      res_dist  <= reach[t_idx] ? b_rdata : '0;
    end

    if ((state == S_RESULT) && out_free) begin
      distance  <= res_dist;
      reachable <= res_reach;
    end
  end

  `SSD_ASSERT_IMP(a_relax_store_read_only, clk, rst,
    state == S_RELAX, !e_we, "edge store written during relaxation")
  `SSD_ASSERT_IMP(a_relax_row_settled, clk, rst,
    state == S_RELAX, settled[u], "relaxed row is not settled")
  `SSD_ASSERT_IMP(a_pick_unsettled, clk, rst,
    (state == S_RELAX) && m_found, reach[m_idx] && !settled[m_idx],
    "next vertex is settled or unreached")
  `SSD_ASSERT_IMP(a_result_source, clk, rst,
    $rose(out_valid), $past(state) == S_RESULT, "result raised outside result state")

endmodule
